/* hw/rtl/vmt_pkg.sv */
package vmt_pkg;

    localparam int MW = 50;        // accumulator / magnitude width
    localparam int CW = MW - 7;    // width of a value entering the clamp
    localparam int QB = 33;        // quotient bits produced by the divider
    localparam int NW = MW + 16;   // dividend width

    typedef enum logic [1:0] {
        ACT_ROT  = 2'd0,
        ACT_INV  = 2'd1,
        ACT_FULL = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef logic signed [MW-1:0] t_acc;
    typedef logic [MW-1:0]        t_mag;
    typedef logic [3:0][63:0]     t_matrix;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_res;

    typedef struct packed {
        t_mag          rem;
        logic [QB-1:0] nq;    // dividend bits still to enter, quotient bits shift in below
        logic          neg;
        logic          ovf;
    } t_lane;

    typedef struct packed {
        logic           use_div;
        logic           dz;
        t_res [2:0]     pre;
    } t_meta;

    function automatic logic signed [15:0] entry(t_matrix m, logic [1:0] r, logic [1:0] c);
        return m[r][{c, 4'b0000} +: 16];
    endfunction

    function automatic t_res clamp(logic neg, logic [CW-1:0] mag);
        t_res res;
        res.sat = 1'b0;
        if (!neg && mag > CW'(32'h7FFF_FFFF)) begin
            res.sat = 1'b1;
            res.val = 32'h7FFF_FFFF;
        end else if (neg && mag > CW'(32'h8000_0000)) begin
            res.sat = 1'b1;
            res.val = 32'h8000_0000;
        end else if (neg) begin
            res.val = 32'd0 - mag[31:0];
        end else begin
            res.val = mag[31:0];
        end
        return res;
    endfunction

    // one restoring step: bring down a dividend bit, subtract if it fits
    function automatic t_lane div_step(t_lane l, t_mag wm);
        t_lane    res;
        logic [MW:0] t;
        logic        ge;
        t   = {l.rem, l.nq[QB-1]};
        ge  = t >= {1'b0, wm};
        res = l;
        res.rem = ge ? MW'(t - {1'b0, wm}) : MW'(t);
        res.nq  = {l.nq[QB-2:0], ge};
        return res;
    endfunction

endpackage

/* hw/rtl/vmt_if.sv */
interface vmt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    modport source(output valid, action, in_x, in_y, in_z, input ready);
    modport sink(input valid, action, in_x, in_y, in_z, output ready);
endinterface

interface vmt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               divide_by_zero;
    logic               saturated;
    modport source(output valid, out_x, out_y, out_z, divide_by_zero, saturated,
                   input ready);
    modport sink(input valid, out_x, out_y, out_z, divide_by_zero, saturated,
                 output ready);
endinterface

interface vmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/vector_matrix_transform.sv */
// channel  dir  payload
// i_in     in   action[1:0], in_x/in_y/in_z signed Q16.16
// o_out    out  out_x/out_y/out_z signed Q16.16, divide_by_zero, saturated
// i_cfg    in   index[1:0] (matrix row), data[63:0]
//
// One item per cycle while the output is taken; stages: input, multiply, sum, magnitude,
// round/prepare, divider set-up, 33 restoring divider steps (one quotient bit
// each), output register. The 33-step divider sets the latency.
// Synchronous active-low reset clears valids and the matrix rows.
// The whole pipeline holds while the output register is full and not taken.
module vector_matrix_transform (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vmt_in_if.sink            i_in,
    vmt_out_if.source         o_out,
    vmt_cfg_if.sink           i_cfg
);

    localparam int QB = vmt_pkg::QB;
    localparam int MW = vmt_pkg::MW;
    localparam int CW = vmt_pkg::CW;
    localparam int NW = vmt_pkg::NW;

    vmt_pkg::t_matrix r_mat;
    logic             r_ov;
    logic             w_en;

    assign w_en        = !r_ov || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
        end else if (i_cfg.valid) begin
            r_mat[i_cfg.index] <= i_cfg.data;
        end
    end

    // stage 1: input
    logic               r1_v;
    vmt_pkg::t_action   r1_act;
    logic signed [31:0] r1_x [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= i_in.valid;
        if (w_en) begin
            r1_act  <= vmt_pkg::t_action'(i_in.action);
            r1_x[0] <= i_in.in_x;
            r1_x[1] <= i_in.in_y;
            r1_x[2] <= i_in.in_z;
        end
    end

    // stage 2: products; row 3 of the product array feeds w
    logic               r2_v;
    vmt_pkg::t_action   r2_act;
    logic signed [47:0] r2_p [4][3];
    logic signed [47:0] n_p  [4][3];

    always_comb begin
        logic signed [15:0] c;
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (j < 3 && r1_act == vmt_pkg::ACT_INV)
                    c = vmt_pkg::entry(r_mat, 2'(j), 2'(i));
                else
                    c = vmt_pkg::entry(r_mat, 2'(i), 2'(j));
                n_p[j][i] = r1_x[i] * c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
        if (w_en) begin
            r2_act <= r1_act;
            r2_p   <= n_p;
        end
    end

    // stage 3: sums plus translation / m44
    logic             r3_v;
    vmt_pkg::t_action r3_act;
    vmt_pkg::t_acc    r3_acc [4];
    vmt_pkg::t_acc    n_acc  [4];

    always_comb begin
        logic signed [15:0] e;
        vmt_pkg::t_acc      t;
        for (int j = 0; j < 4; j++) begin
            e = vmt_pkg::entry(r_mat, 2'd3, 2'(j));
            t = {{(MW-32){e[15]}}, e, 16'h0000};
            if (r2_act != vmt_pkg::ACT_FULL) t = '0;
            n_acc[j] = MW'(r2_p[j][0]) + MW'(r2_p[j][1]) + MW'(r2_p[j][2]) + t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
        if (w_en) begin
            r3_act <= r2_act;
            r3_acc <= n_acc;
        end
    end

    // stage 4: sign and magnitude
    logic             r4_v;
    vmt_pkg::t_action r4_act;
    logic [3:0]       r4_neg;
    vmt_pkg::t_mag    r4_mag [4];
    logic             r4_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= r3_v;
        if (w_en) begin
            r4_act <= r3_act;
            r4_dz  <= (r3_act == vmt_pkg::ACT_FULL) && (r3_acc[3] == '0);
            for (int j = 0; j < 4; j++) begin
                r4_neg[j] <= r3_acc[j][MW-1];
                r4_mag[j] <= r3_acc[j][MW-1] ? MW'(-r3_acc[j]) : MW'(r3_acc[j]);
            end
        end
    end

    // stage 5: rotate rounding and clamp, special cases, dividend set-up
    logic            r5_v;
    vmt_pkg::t_meta  r5_meta;
    vmt_pkg::t_mag   r5_wm;
    logic [2:0]      r5_neg;
    logic [NW-1:0]   r5_n [3];
    vmt_pkg::t_meta  n5_meta;

    always_comb begin
        logic [MW:0] s;
        n5_meta.use_div = (r4_act == vmt_pkg::ACT_FULL) && !r4_dz;
        n5_meta.dz      = r4_dz;
        for (int j = 0; j < 3; j++) begin
            s = {1'b0, r4_mag[j]} + (MW+1)'(128);
            n5_meta.pre[j] = '0;
            case (r4_act)
                vmt_pkg::ACT_ROT,
                vmt_pkg::ACT_INV:  n5_meta.pre[j] = vmt_pkg::clamp(r4_neg[j], s[MW:8]);
                vmt_pkg::ACT_FULL: begin
                    if (r4_dz && r4_mag[j] != '0)
                        n5_meta.pre[j] = vmt_pkg::clamp(r4_neg[j], '1);
                end
                default:           n5_meta.pre[j] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= r4_v;
        if (w_en) begin
            r5_meta <= n5_meta;
            r5_wm   <= r4_mag[3];
            for (int j = 0; j < 3; j++) begin
                r5_neg[j] <= r4_neg[j] ^ r4_neg[3];
                r5_n[j]   <= {r4_mag[j], 16'h0000} + NW'(r4_mag[3] >> 1);
            end
        end
    end

    // divider: stage 0 set-up, then one quotient bit per stage
    logic           r_dv  [QB+1];
    vmt_pkg::t_meta r_dm  [QB+1];
    vmt_pkg::t_mag  r_dwm [QB+1];
    vmt_pkg::t_lane r_dl  [QB+1][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (w_en) r_dv[0] <= r5_v;
        if (w_en) begin
            r_dm[0]  <= r5_meta;
            r_dwm[0] <= r5_wm;
            for (int j = 0; j < 3; j++) begin
                // quotient of 2^33 or more can only clamp
                r_dl[0][j].ovf <= MW'(r5_n[j][NW-1:QB]) >= r5_wm;
                r_dl[0][j].rem <= MW'(r5_n[j][NW-1:QB]);
                r_dl[0][j].nq  <= r5_n[j][QB-1:0];
                r_dl[0][j].neg <= r5_neg[j];
            end
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[k] <= 1'b0;
            else if (w_en) r_dv[k] <= r_dv[k-1];
            if (w_en) begin
                r_dm[k]  <= r_dm[k-1];
                r_dwm[k] <= r_dwm[k-1];
                for (int j = 0; j < 3; j++)
                    r_dl[k][j] <= vmt_pkg::div_step(r_dl[k-1][j], r_dwm[k-1]);
            end
        end
    end

    // output register
    vmt_pkg::t_res      n_res [3];
    logic signed [31:0] r_ox [3];
    logic               r_odz;
    logic               r_osat;

    always_comb begin
        logic [CW-1:0] m;
        for (int j = 0; j < 3; j++) begin
            m = r_dl[QB][j].ovf ? '1 : CW'(r_dl[QB][j].nq);
            if (r_dm[QB].use_div)
                n_res[j] = vmt_pkg::clamp(r_dl[QB][j].neg, m);
            else
                n_res[j] = r_dm[QB].pre[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r_dv[QB];
        if (w_en) begin
            for (int j = 0; j < 3; j++) r_ox[j] <= n_res[j].val;
            r_odz  <= r_dm[QB].dz;
            r_osat <= n_res[0].sat | n_res[1].sat | n_res[2].sat;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.out_x          = r_ox[0];
    assign o_out.out_y          = r_ox[1];
    assign o_out.out_z          = r_ox[2];
    assign o_out.divide_by_zero = r_odz;
    assign o_out.saturated      = r_osat;

endmodule
